### rtl/core/gpbc_pkg.sv
package gpbc_pkg;

   localparam int unsigned SIDE_W = 7;    // size registers and source indexes
   localparam int unsigned PROD_W = 14;   // coordinate products and dividends
   localparam int unsigned RADDR_W = 12;  // full bitmap read address
   localparam int unsigned INK_W = 16;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [2:0] CSR_SOURCE_WIDTH = 3'd0;
   localparam logic [2:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_TARGET_WIDTH = 3'd2;
   localparam logic [2:0] CSR_TARGET_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_BITS_PER_PIXEL = 3'd4;
   localparam logic [2:0] CSR_GLYPH_MISSING = 3'd5;
   localparam logic [2:0] CSR_BITMAP_VALID = 3'd6;

   localparam logic [1:0] DIV_LEFT = 2'd0;
   localparam logic [1:0] DIV_RIGHT = 2'd1;
   localparam logic [1:0] DIV_TOP = 2'd2;
   localparam logic [1:0] DIV_BOTTOM = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ROW,
      ST_ROW_W,
      ST_CELL_RD,
      ST_CELL_MUL,
      ST_CELL_ACC,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       setup;
      logic       div_start;
      logic       div_capture;
      logic [1:0] div_sel;
      logic       row_init;
      logic       row_wy;
      logic       cell_rd;
      logic       cell_mul;
      logic       cell_acc;
      logic       row_step;
      logic       decide;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic div_done;
      logic cell_last;
      logic row_last;
      logic rsp_free;
   } status_type;

endpackage

### rtl/core/gpbc_div.sv
module gpbc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gpbc_pkg::PROD_W-1:0]   dividend,
   input  logic [gpbc_pkg::SIDE_W-1:0]   divisor,
   output logic [gpbc_pkg::PROD_W-1:0]   quotient,
   output logic                          done
);
   import gpbc_pkg::*;

   logic [PROD_W-1:0] quo_ff;
   logic [SIDE_W-1:0] rem_ff;
   logic [3:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [SIDE_W:0]   shifted;

   // one quotient bit a cycle, restoring
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 4'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         cnt_ff <= 4'(PROD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 4'd1;
         if (shifted >= {1'b0, divisor}) begin
            rem_ff <= SIDE_W'(shifted - {1'b0, divisor});
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[SIDE_W-1:0];
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;
endmodule

### rtl/core/gpbc_ctrl.sv
module gpbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 query_accept,
   input  gpbc_pkg::status_type status,
   output gpbc_pkg::cmd_type    cmd,
   output logic                 busy
);
   import gpbc_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= DIV_LEFT;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      unique case (state_ff)
         ST_IDLE:     if (query_accept) state_in = ST_SETUP;
         ST_SETUP: begin
            sel_in = DIV_LEFT;
            state_in = status.early ? ST_RESP : ST_DIV_GO;
         end
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (status.div_done) begin
            sel_in = sel_ff + 2'd1;
            state_in = (sel_ff == DIV_BOTTOM) ? ST_ROW : ST_DIV_GO;
         end
         ST_ROW:      state_in = ST_ROW_W;
         ST_ROW_W:    state_in = ST_CELL_RD;
         ST_CELL_RD:  state_in = ST_CELL_MUL;
         ST_CELL_MUL: state_in = ST_CELL_ACC;
         ST_CELL_ACC: begin
            if (!status.cell_last) state_in = ST_CELL_RD;
            else if (!status.row_last) state_in = ST_ROW;
            else state_in = ST_DECIDE;
         end
         ST_DECIDE:   state_in = ST_RESP;
         ST_RESP:     if (status.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = sel_ff;
      unique case (state_ff)
         ST_SETUP:    cmd.setup = 1'b1;
         ST_DIV_GO:   cmd.div_start = 1'b1;
         ST_DIV_WAIT: cmd.div_capture = status.div_done;
         ST_ROW:      cmd.row_init = 1'b1;
         ST_ROW_W:    cmd.row_wy = 1'b1;
         ST_CELL_RD:  cmd.cell_rd = 1'b1;
         ST_CELL_MUL: cmd.cell_mul = 1'b1;
         ST_CELL_ACC: begin
            cmd.cell_acc = 1'b1;
            cmd.row_step = status.cell_last;
         end
         ST_DECIDE:   cmd.decide = 1'b1;
         ST_RESP:     cmd.respond = status.rsp_free;
         default:     cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

### rtl/core/gpbc_dp.sv
module gpbc_dp #(
   parameter int unsigned BITMAP_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [6:0]           csr_write_data,
   input  logic                 req_accept,
   input  logic                 req_command,
   input  logic [9:0]           req_byte_address,
   input  logic [7:0]           req_byte_value,
   input  logic signed [7:0]    req_pixel_x,
   input  logic signed [7:0]    req_pixel_y,
   input  gpbc_pkg::cmd_type    cmd,
   output gpbc_pkg::status_type status,
   output logic                 rsp_valid,
   output logic                 rsp_pixel_on,
   input  logic                 rsp_stall
);
   import gpbc_pkg::*;

   localparam int unsigned AW = $clog2(BITMAP_BYTES);

   // configuration
   logic [SIDE_W-1:0] sw_ff, sh_ff, tw_ff, th_ff;
   logic [1:0]        bpp_ff;
   logic              missing_ff, valid_ff;

   logic [7:0]        bitmap_mem_ff [BITMAP_BYTES];
   logic [7:0]        rd_data_ff;
   logic              rd_oob_ff;

   logic signed [7:0] x_ff, y_ff;
   logic [PROD_W-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic [SIDE_W-1:0] sx0_ff, sx1_ff, sy1_ff, sx_ff, sy_ff;
   logic [PROD_W-1:0] sy_th_ff;
   logic [RADDR_W-1:0] rowbase_ff;
   logic [SIDE_W-1:0] wy_ff, wx_ff;
   logic [PROD_W-1:0] wxy_ff;
   logic [1:0]        level_ff;
   logic [INK_W-1:0]  ink_ff;
   logic              result_ff;
   logic              rsp_valid_ff, rsp_on_ff;

   logic [SIDE_W-1:0] xs, ys;
   logic              outside, on_edge, invalid;
   logic [5:0]        stride;
   logic [8:0]        row_bits;
   logic [PROD_W-1:0] div_dividend, div_quotient;
   logic [SIDE_W-1:0] div_divisor;
   logic              div_done;
   logic [PROD_W-1:0] sx_tw, lo_x, hi_x, lo_y, hi_y, sy_th_hi;
   logic [RADDR_W-1:0] rd_addr;
   logic [31:0]       rd_full, wr_full;
   logic [1:0]        level;
   logic [INK_W:0]    area3;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= '0;
         sh_ff <= '0;
         tw_ff <= '0;
         th_ff <= '0;
         bpp_ff <= 2'd1;
         missing_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:   sw_ff <= csr_write_data;
            CSR_SOURCE_HEIGHT:  sh_ff <= csr_write_data;
            CSR_TARGET_WIDTH:   tw_ff <= csr_write_data;
            CSR_TARGET_HEIGHT:  th_ff <= csr_write_data;
            CSR_BITS_PER_PIXEL: bpp_ff <= csr_write_data[1:0];
            CSR_GLYPH_MISSING:  missing_ff <= csr_write_data[0];
            CSR_BITMAP_VALID:   valid_ff <= csr_write_data[0];
            default:            ;
         endcase
      end
   end

   // bitmap store, writes beyond the store are dropped
   assign wr_full = 32'(req_byte_address);
   always_ff @(posedge clock) begin
      if (req_accept && req_command == CMD_WRITE && wr_full < 32'(BITMAP_BYTES)) begin
         bitmap_mem_ff[wr_full[AW-1:0]] <= req_byte_value;
      end
   end

   assign row_bits = (bpp_ff == 2'd2) ? {1'b0, sw_ff, 1'b0} : {2'b0, sw_ff};
   assign stride = 6'((row_bits + 9'd7) >> 3);
   assign rd_addr = rowbase_ff + ((bpp_ff == 2'd2) ? RADDR_W'(sx_ff >> 2)
                                                   : RADDR_W'(sx_ff >> 3));
   assign rd_full = 32'(rd_addr);

   always_ff @(posedge clock) begin
      if (cmd.cell_rd) begin
         rd_data_ff <= bitmap_mem_ff[rd_full[AW-1:0]];
         rd_oob_ff <= (rd_full >= 32'(BITMAP_BYTES));
      end
   end

   // quick answers
   assign xs = x_ff[6:0];
   assign ys = y_ff[6:0];
   assign outside = x_ff[7] || y_ff[7] || xs >= tw_ff || ys >= th_ff;
   assign on_edge = xs == '0 || ys == '0 || ({1'b0, xs} + 8'd1) == {1'b0, tw_ff}
                    || ({1'b0, ys} + 8'd1) == {1'b0, th_ff};
   assign invalid = !valid_ff || sw_ff == '0 || sh_ff == '0
                    || (bpp_ff != 2'd1 && bpp_ff != 2'd2);
   assign status.early = outside || missing_ff || invalid;

   always_comb begin
      case (cmd.div_sel)
         DIV_LEFT:   div_dividend = left_ff;
         DIV_RIGHT:  div_dividend = right_ff + PROD_W'(tw_ff) - PROD_W'(1);
         DIV_TOP:    div_dividend = top_ff;
         default:    div_dividend = bottom_ff + PROD_W'(th_ff) - PROD_W'(1);
      endcase
   end
   assign div_divisor = cmd.div_sel[1] ? th_ff : tw_ff;

   gpbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // overlap of the current source column and row with the target box
   assign sx_tw = PROD_W'(sx_ff) * PROD_W'(tw_ff);
   assign lo_x = (sx_tw > left_ff) ? sx_tw : left_ff;
   assign hi_x = ((sx_tw + PROD_W'(tw_ff)) < right_ff) ? (sx_tw + PROD_W'(tw_ff)) : right_ff;
   assign sy_th_hi = sy_th_ff + PROD_W'(th_ff);
   assign lo_y = (sy_th_ff > top_ff) ? sy_th_ff : top_ff;
   assign hi_y = (sy_th_hi < bottom_ff) ? sy_th_hi : bottom_ff;

   always_comb begin
      if (bpp_ff == 2'd2) begin
         level = 2'((rd_data_ff >> (3'd6 - {sx_ff[1:0], 1'b0})) & 8'd3);
      end else begin
         level = rd_data_ff[3'd7 - sx_ff[2:0]] ? 2'd3 : 2'd0;
      end
   end

   assign area3 = (INK_W+1)'(PROD_W'(sw_ff) * PROD_W'(sh_ff)) * (INK_W+1)'(3);

   always_ff @(posedge clock) begin
      if (req_accept && req_command == CMD_QUERY) begin
         x_ff <= req_pixel_x;
         y_ff <= req_pixel_y;
      end
      if (cmd.setup) begin
         left_ff <= PROD_W'(xs) * PROD_W'(sw_ff);
         right_ff <= PROD_W'(xs) * PROD_W'(sw_ff) + PROD_W'(sw_ff);
         top_ff <= PROD_W'(ys) * PROD_W'(sh_ff);
         bottom_ff <= PROD_W'(ys) * PROD_W'(sh_ff) + PROD_W'(sh_ff);
         ink_ff <= '0;
         result_ff <= !outside && missing_ff && on_edge;
      end
      if (cmd.div_capture) begin
         case (cmd.div_sel)
            DIV_LEFT:  sx0_ff <= div_quotient[SIDE_W-1:0];
            DIV_RIGHT: sx1_ff <= div_quotient[SIDE_W-1:0];
            DIV_TOP:   sy_ff <= div_quotient[SIDE_W-1:0];
            default:   sy1_ff <= div_quotient[SIDE_W-1:0];
         endcase
      end
      if (cmd.row_init) begin
         sy_th_ff <= PROD_W'(sy_ff) * PROD_W'(th_ff);
         rowbase_ff <= RADDR_W'(sy_ff) * RADDR_W'(stride);
      end
      if (cmd.row_wy) begin
         wy_ff <= SIDE_W'(hi_y - lo_y);
         sx_ff <= sx0_ff;
      end
      if (cmd.cell_rd) begin
         wx_ff <= SIDE_W'(hi_x - lo_x);
      end
      if (cmd.cell_mul) begin
         wxy_ff <= PROD_W'(wx_ff) * PROD_W'(wy_ff);
         level_ff <= rd_oob_ff ? 2'd0 : level;
      end
      if (cmd.cell_acc) begin
         ink_ff <= ink_ff + INK_W'(level_ff) * INK_W'(wxy_ff);
         sx_ff <= sx_ff + SIDE_W'(1);
      end
      if (cmd.row_step) begin
         sy_ff <= sy_ff + SIDE_W'(1);
      end
      if (cmd.decide) begin
         result_ff <= {ink_ff, 1'b0} >= area3;
      end
   end

   assign status.div_done = div_done;
   assign status.cell_last = ({1'b0, sx_ff} + 8'd1) >= {1'b0, sx1_ff};
   assign status.row_last = ({1'b0, sy_ff} + 8'd1) >= {1'b0, sy1_ff};
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_on_ff <= result_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_on = rsp_on_ff;
endmodule

### rtl/core/glyph_pixel_box_coverage_core.sv
// channel  direction  ports
// request  in         req_valid, req_stall, req_command, req_byte_address,
//                     req_byte_value, req_pixel_x, req_pixel_y
// response out        rsp_valid, rsp_stall, rsp_pixel_on
// csr      in         csr_write_enable, csr_index, csr_write_data
//
// A write request gives no response. A query is answered early, without the divider,
// when it falls outside the target, hits a missing glyph or an invalid setting;
// otherwise it runs four divisions on the shared restoring divider, then reads each
// overlapped source pixel through the single bitmap read port, row by row.
// Reset is synchronous and clears control and configuration; the bitmap store
// is not cleared. A stalled response holds in its register while the next
// request is already taken.
module glyph_pixel_box_coverage_core #(
   parameter int unsigned BITMAP_BYTES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [9:0]        req_byte_address,
   input  logic [7:0]        req_byte_value,
   input  logic signed [7:0] req_pixel_x,
   input  logic signed [7:0] req_pixel_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_pixel_on
);
   import gpbc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy;
   logic       req_accept;

   // hold off new requests while a query is being worked
   assign req_stall = busy;
   assign req_accept = req_valid && !req_stall;

   gpbc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .query_accept (req_accept && req_command == CMD_QUERY),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   gpbc_dp #(
      .BITMAP_BYTES (BITMAP_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_accept       (req_accept),
      .req_command      (req_command),
      .req_byte_address (req_byte_address),
      .req_byte_value   (req_byte_value),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_stall        (rsp_stall)
   );
endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import gpbc_pkg::*;

   localparam int STORE_BYTES = 1024;
   localparam int IDLE_LIMIT = 200000;   // a full 127x127 downscale query takes the longest

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [2:0]        csr_index;
   logic [6:0]        csr_write_data;
   logic              req_valid;
   logic              req_stall;
   logic              req_command;
   logic [9:0]        req_byte_address;
   logic [7:0]        req_byte_value;
   logic signed [7:0] req_pixel_x;
   logic signed [7:0] req_pixel_y;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_pixel_on;

   glyph_pixel_box_coverage_core dut (.*);

   // Clock: 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mirror of the glyph bitmap and the configuration registers.
   logic [7:0] glyph_bytes [STORE_BYTES];
   int src_w, src_h, tgt_w, tgt_h, depth, missing_glyph, bitmap_ok;

   bit pending_pixels [$];   // expected pixel_on, oldest first
   int error_count;
   int idle_cycles;
   int burst_left;
   int hold_request;         // long receiver hold-off asked by a test
   int hold_left;
   int stall_mode;
   int stall_phase;

   // Source level of one bitmap sample: 1bpp maps to 0 or 3.
   function automatic int sample_level(int sx, int sy);
      int stride;
      int addr;
      int b;
      stride = (src_w * depth + 7) / 8;
      addr = sy * stride + ((depth == 1) ? sx / 8 : sx / 4);
      b = (addr >= STORE_BYTES) ? 0 : int'(glyph_bytes[addr]);
      if (depth == 1)
         return ((b >> (7 - sx % 8)) & 1) ? 3 : 0;
      return (b >> (6 - 2 * (sx % 4))) & 3;
   endfunction

   // Expected ink for target pixel (x, y) under the mirrored settings.
   function automatic bit pixel_coverage(int x, int y);
      int left, right, top, bottom, ink, wx, wy;
      if (x < 0 || y < 0 || x >= tgt_w || y >= tgt_h)
         return 1'b0;
      if (missing_glyph != 0)
         return (x == 0 || y == 0 || x == tgt_w - 1 || y == tgt_h - 1);
      if (bitmap_ok == 0 || src_w == 0 || src_h == 0 || (depth != 1 && depth != 2))
         return 1'b0;
      if (tgt_w == src_w && tgt_h == src_h)
         return sample_level(x, y) >= 2;
      left = x * src_w;
      right = (x + 1) * src_w;
      top = y * src_h;
      bottom = (y + 1) * src_h;
      ink = 0;
      for (int sy = top / tgt_h; sy < (bottom + tgt_h - 1) / tgt_h; sy++) begin
         wy = ((bottom < (sy + 1) * tgt_h) ? bottom : (sy + 1) * tgt_h) -
              ((top > sy * tgt_h) ? top : sy * tgt_h);
         for (int sx = left / tgt_w; sx < (right + tgt_w - 1) / tgt_w; sx++) begin
            wx = ((right < (sx + 1) * tgt_w) ? right : (sx + 1) * tgt_w) -
                 ((left > sx * tgt_w) ? left : sx * tgt_w);
            ink += sample_level(sx, sy) * wx * wy;
         end
      end
      return ink * 2 >= 3 * src_w * src_h;
   endfunction

   // Offer one request, hold it until taken, then update the mirror.
   task automatic send_request(logic command, logic [9:0] addr, logic [7:0] value,
                               logic [7:0] px, logic [7:0] py);
      req_command <= command;
      req_byte_address <= addr;
      req_byte_value <= value;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (command == CMD_WRITE)
         glyph_bytes[addr] = value;
      else
         pending_pixels.push_back(pixel_coverage(int'($signed(px)), int'($signed(py))));
      // Bursts of random length, then drop valid for a random gap.
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
   endtask

   task automatic send_write(int addr, int value);
      send_request(CMD_WRITE, 10'(addr), 8'(value), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_query(int x, int y);
      send_request(CMD_QUERY, 10'($urandom), 8'($urandom), 8'(x), 8'(y));
   endtask

   // Stop offering and wait until every expected pixel has come back.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all registers while the block is idle.
   task automatic set_config(int sw, int sh, int tw, int th, int bpp, int miss, int ok);
      int vals [7];
      logic [2:0] idx [7];
      vals = '{sw, sh, tw, th, bpp, miss, ok};
      idx = '{CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT, CSR_TARGET_WIDTH, CSR_TARGET_HEIGHT,
              CSR_BITS_PER_PIXEL, CSR_GLYPH_MISSING, CSR_BITMAP_VALID};
      drain_block();
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= 7'(vals[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      src_w = sw & 127;
      src_h = sh & 127;
      tgt_w = tw & 127;
      tgt_h = th & 127;
      depth = bpp & 3;
      missing_glyph = miss & 1;
      bitmap_ok = ok & 1;
   endtask

   // Fill the whole store so no query can ever read an unwritten byte.
   task automatic test_fill_store();
      for (int a = 0; a < STORE_BYTES; a++)
         send_write(a, $urandom_range(0, 255));
   endtask

   task automatic test_directed();
      // Equal size, 1bpp, corners and coordinate extremes.
      set_config(8, 8, 8, 8, 1, 0, 1);
      send_query(0, 0);
      send_query(7, 7);
      send_query(-128, 0);
      send_query(0, 127);
      send_query(8, 3);
      // Equal size at 2bpp.
      set_config(5, 3, 5, 3, 2, 0, 1);
      send_query(4, 2);
      send_query(1, 1);
      // Missing glyph outline, checked ahead of invalid bitmap.
      set_config(0, 0, 6, 5, 0, 1, 0);
      send_query(0, 2);
      send_query(5, 4);
      send_query(2, 2);
      // Invalid settings: no bitmap, bpp 0 and 3, zero source, zero target.
      set_config(4, 4, 7, 7, 1, 0, 0);
      send_query(3, 3);
      set_config(4, 4, 7, 7, 3, 0, 1);
      send_query(3, 3);
      set_config(4, 4, 7, 7, 0, 0, 1);
      send_query(3, 3);
      set_config(0, 4, 7, 7, 1, 0, 1);
      send_query(3, 3);
      set_config(4, 4, 0, 0, 1, 0, 1);
      send_query(0, 0);
      // Register maxima: equal 127 size reads past the store, upscale from 1.
      set_config(127, 127, 127, 127, 2, 0, 1);
      send_query(126, 126);
      send_query(10, 3);
      set_config(1, 1, 127, 127, 1, 0, 1);
      send_query(126, 0);
      // Full downscale of the largest source onto one pixel (slow).
      set_config(127, 127, 1, 1, 1, 0, 1);
      send_query(0, 0);
      set_config(127, 9, 2, 1, 2, 0, 1);
      send_query(1, 0);
   endtask

   // Receiver holds off for a long stretch while queries keep coming.
   task automatic test_backpressure();
      set_config(12, 10, 7, 9, 2, 0, 1);
      hold_request = 400;
      for (int i = 0; i < 12; i++)
         send_query($urandom_range(0, 6), $urandom_range(0, 8));
      drain_block();
   endtask

   task automatic test_random(int phases);
      int sw, sh, tw, th, bpp, n;
      for (int p = 0; p < phases; p++) begin
         sw = $urandom_range(1, 16);
         sh = $urandom_range(1, 16);
         tw = ($urandom_range(0, 3) == 0) ? sw : $urandom_range(0, 24);
         th = ($urandom_range(0, 3) == 0) ? sh : $urandom_range(0, 24);
         bpp = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
         set_config(sw, sh, tw, th, bpp, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) != 0);
         n = $urandom_range(15, 45);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
               send_write($urandom_range(0, 1023), $urandom_range(0, 255));
            else if ($urandom_range(0, 9) == 0)
               send_query($urandom_range(0, 255), $urandom_range(0, 255));
            else
               send_query($urandom_range(0, tw), $urandom_range(0, th));
         end
         if ($urandom_range(0, 5) == 0)
            drain_block();
      end
   endtask

   // Receiver stall pattern: off, random, or periodic; switch modes now and then.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= (stall_phase % 9 < 4);
         endcase
         if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
      end
   end

   // Check each accepted pixel against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected response, pixel_on=%0b", $time, rsp_pixel_on);
            error_count++;
         end else if (pending_pixels[0] !== rsp_pixel_on) begin
            $display("%0t: pixel_on mismatch, expected %0b, actual %0b",
                     $time, pending_pixels[0], rsp_pixel_on);
            error_count++;
            void'(pending_pixels.pop_front());
         end else begin
            void'(pending_pixels.pop_front());
         end
      end
   end

   // Watchdog: end the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      hold_request = 0;
      hold_left = 0;
      stall_mode = 0;
      stall_phase = 0;
      burst_left = 8;
      src_w = 0;
      src_h = 0;
      tgt_w = 0;
      tgt_h = 0;
      depth = 1;
      missing_glyph = 0;
      bitmap_ok = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_byte_address = '0;
      req_byte_value = '0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      rsp_stall = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_store();
      test_directed();
      test_backpressure();
      test_random(24);
      drain_block();

      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/core/gpbc_pkg.sv
rtl/core/gpbc_div.sv
rtl/core/gpbc_ctrl.sv
rtl/core/gpbc_dp.sv
rtl/core/glyph_pixel_box_coverage_core.sv
verif/tb.sv
